// ===== sv/plfs_pkg.sv =====
// Shared types, constants and defaults for the presence LED fade sequencer.
package plfs_pkg;

  // Default parameter values.
  localparam int DEF_QUEUE_DEPTH = 5;
  localparam int DEF_RAMP_STEPS  = 100;
  localparam int DEF_PWM_TOP     = 999;

  // Field widths.
  localparam int POT_W   = 12;
  localparam int DUTY_W  = 10;
  localparam int LEVEL_W = 7;
  localparam int TGT_W   = 16;
  localparam int NUM_CH  = 4;
  localparam int CH_W    = $clog2(NUM_CH);

  // Full-scale pot reading; 4095 is 2**POT_W - 1, which the fold step relies on.
  localparam int POT_FULL = 4095;

  // Shared multiply-accumulate unit widths.
  localparam int ALU_A_W = 16;
  localparam int ALU_B_W = 17;
  localparam int ALU_W   = 34;

  // Request command codes.
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic             command;
    logic             pin_level;
    logic [POT_W-1:0] pot_a;
    logic [POT_W-1:0] pot_b;
    logic [POT_W-1:0] pot_c;
    logic [POT_W-1:0] pot_d;
  } plfs_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty_a;
    logic [DUTY_W-1:0]  duty_b;
    logic [DUTY_W-1:0]  duty_c;
    logic [DUTY_W-1:0]  duty_d;
    logic [LEVEL_W-1:0] level;
    logic               fading_up;
    logic               final_step;
  } plfs_out_t;

  // Operation select for the multiply-accumulate unit.
  typedef struct packed {
    logic sub;
    logic cin;
  } plfs_alu_ctl_t;

  // Request queue status.
  typedef struct packed {
    logic empty;
    logic full;
  } plfs_q_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_STEP,
    ST_EMIT
  } plfs_state_t;

  // Sequencer phases: the first seven set up a channel at fade start,
  // the last four advance a channel by one ramp step.
  typedef enum logic [3:0] {
    PH_MUL_LO,
    PH_FOLD,
    PH_MUL_HI,
    PH_RECIP,
    PH_REM,
    PH_CHECK,
    PH_FIX,
    PH_ADD,
    PH_WRAP,
    PH_CARRY,
    PH_STORE
  } plfs_phase_t;

endpackage

// ===== sv/plfs_alu.sv =====
// Shared multiply-accumulate unit: acc = c +/- a*b + cin, registered.
module plfs_alu import plfs_pkg::*; (
  input  logic               clk,
  input  logic [ALU_A_W-1:0] a,
  input  logic [ALU_B_W-1:0] b,
  input  logic [ALU_W-1:0]   c,
  input  plfs_alu_ctl_t      ctl,
  output logic [ALU_W-1:0]   acc_r
);

  logic [ALU_A_W+ALU_B_W-1:0] prod;
  logic [ALU_W-1:0]           term;
  logic [ALU_W-1:0]           acc_nxt;

  // Product, optionally inverted so that cin completes a two's complement subtract.
  always_comb begin
    prod    = ALU_A_W'(a) * ALU_B_W'(b);
    term    = ctl.sub ? ~ALU_W'(prod) : ALU_W'(prod);
    acc_nxt = c + term + ALU_W'(ctl.cin);
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

// ===== sv/plfs_queue.sv =====
// Circular queue of pending fade requests (1 = fade up, 0 = fade down).
module plfs_queue import plfs_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic         push_up,
  input  logic         pop,
  output logic         pop_up,
  output plfs_q_stat_t stat
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(2 * DEPTH);

  logic          mem_r [DEPTH];
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] sum;
  logic [SW-1:0] tail;
  logic          do_push;
  logic          do_pop;

  // Status and the write slot behind the oldest entry.
  always_comb begin
    stat.empty = (count_r == '0);
    stat.full  = (count_r == CW'(DEPTH));
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    sum        = SW'(head_r) + SW'(count_r);
    tail       = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
    pop_up     = mem_r[head_r];
  end

  // Pointer and fill count update; a request into a full queue is dropped.
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (do_pop) begin
      head_nxt  = (head_r == IW'(DEPTH - 1)) ? '0 : head_r + IW'(1);
      count_nxt = count_r - CW'(1);
    end
    if (do_push) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage, no reset: an entry is read only after it was written.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[tail[IW-1:0]] <= push_up;
    end
  end

endmodule

// ===== sv/presence_led_fade_sequencer_unit.sv =====
// Top level of the presence-driven four-channel LED fade sequencer.
// A presence sample never gives a result: a change of the pin level queues a fade-up or
// fade-down request, dropped when the queue is full. A tick that starts a fade accepts the
// request, scales each channel's pot to a target and splits it by the step count, then
// presents the result; a tick inside a running fade accepts the request, advances each
// channel's running quotient and remainder, then presents. A tick with nothing to do gives
// no result. All arithmetic goes through one multiply-accumulate unit that serves the four
// channels in turn. The result sits in an output register, so the next request is taken
// while it waits.
module presence_led_fade_sequencer_unit import plfs_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int RAMP_STEPS  = DEF_RAMP_STEPS,
  parameter int PWM_TOP     = DEF_PWM_TOP
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  plfs_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output plfs_out_t out_data
);

  // Step counter width, also the width of a remainder modulo RAMP_STEPS.
  localparam int SW = $clog2(RAMP_STEPS + 1);

  // target = pot*SCALE_HI + floor(pot*SCALE_LO / 4095)
  localparam int SCALE_HI = PWM_TOP / POT_FULL;
  localparam int SCALE_LO = PWM_TOP % POT_FULL;
  // Reciprocal estimate of 1/RAMP_STEPS; the quotient it gives is low by at most one.
  localparam int RECIP    = (1 << TGT_W) / RAMP_STEPS;

  localparam logic [ALU_B_W-1:0] B_HI    = ALU_B_W'(SCALE_HI);
  localparam logic [ALU_B_W-1:0] B_LO    = ALU_B_W'(SCALE_LO);
  localparam logic [ALU_B_W-1:0] B_RECIP = ALU_B_W'(RECIP);
  localparam logic [ALU_B_W-1:0] B_STEPS = ALU_B_W'(RAMP_STEPS);
  localparam logic [ALU_B_W-1:0] B_ONE   = ALU_B_W'(1);
  localparam logic [ALU_A_W-1:0] A_STEPS = ALU_A_W'(RAMP_STEPS);
  localparam logic [SW-1:0]      STEP_TOP = SW'(RAMP_STEPS);
  localparam logic [CH_W-1:0]    CH_LAST  = CH_W'(NUM_CH - 1);

  plfs_state_t  state_r, state_nxt;
  plfs_phase_t  ph_r, ph_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;

  logic          present_r, present_nxt;
  logic          active_r, active_nxt;
  logic          dir_r, dir_nxt;
  logic [SW-1:0] step_r, step_nxt;

  // Per-channel running duty: duty = tq*step + carries, kept as quotient and remainder.
  logic [POT_W-1:0] pot_r [NUM_CH];
  logic [POT_W-1:0] pot_nxt [NUM_CH];
  logic [TGT_W-1:0] q_r [NUM_CH];
  logic [TGT_W-1:0] q_nxt [NUM_CH];
  logic [SW-1:0]    r_r [NUM_CH];
  logic [SW-1:0]    r_nxt [NUM_CH];
  logic [TGT_W-1:0] tq_r [NUM_CH];
  logic [TGT_W-1:0] tq_nxt [NUM_CH];
  logic [SW-1:0]    tr_r [NUM_CH];
  logic [SW-1:0]    tr_nxt [NUM_CH];
  logic [TGT_W-1:0] tgt_r, tgt_nxt;
  logic [SW-1:0]    v_r, v_nxt;
  logic             vneg_r, vneg_nxt;

  logic      out_valid_r, out_valid_nxt;
  plfs_out_t out_data_r, out_data_nxt;

  logic               ramp_last;
  logic               acc_neg;
  logic               carry;
  logic [ALU_A_W-1:0] alu_a;
  logic [ALU_B_W-1:0] alu_b;
  logic [ALU_W-1:0]   alu_c;
  plfs_alu_ctl_t      alu_ctl;
  logic [ALU_W-1:0]   alu_acc;

  logic         q_push;
  logic         q_push_up;
  logic         q_pop;
  logic         q_pop_up;
  plfs_q_stat_t q_stat;

  plfs_alu u_alu (
    .clk   (clk),
    .a     (alu_a),
    .b     (alu_b),
    .c     (alu_c),
    .ctl   (alu_ctl),
    .acc_r (alu_acc)
  );

  plfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_up (q_push_up),
    .pop     (q_pop),
    .pop_up  (q_pop_up),
    .stat    (q_stat)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Last step of the ramp in its current direction.
  assign ramp_last = dir_r ? (step_r >= STEP_TOP) : (step_r == '0);
  assign acc_neg   = alu_acc[ALU_W-1];

  // Sequencer: next state, datapath updates and operand selection for the shared unit.
  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    ch_nxt        = ch_r;
    present_nxt   = present_r;
    active_nxt    = active_r;
    dir_nxt       = dir_r;
    step_nxt      = step_r;
    pot_nxt       = pot_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    tq_nxt        = tq_r;
    tr_nxt        = tr_r;
    tgt_nxt       = tgt_r;
    v_nxt         = v_r;
    vneg_nxt      = vneg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_push        = 1'b0;
    q_push_up     = 1'b0;
    q_pop         = 1'b0;
    carry         = 1'b0;
    alu_a         = '0;
    alu_b         = '0;
    alu_c         = '0;
    alu_ctl       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.command == CMD_SAMPLE) begin
            // A change of the pin level queues a fade in that direction.
            if (in_data.pin_level != present_r) begin
              present_nxt = in_data.pin_level;
              q_push      = 1'b1;
              q_push_up   = in_data.pin_level;
            end
          end else if (active_r && !ramp_last) begin
            step_nxt  = dir_r ? step_r + SW'(1) : step_r - SW'(1);
            ch_nxt    = '0;
            ph_nxt    = PH_ADD;
            state_nxt = ST_STEP;
          end else begin
            // The running fade is over; start the oldest waiting one, if any.
            active_nxt = 1'b0;
            if (!q_stat.empty) begin
              q_pop      = 1'b1;
              dir_nxt    = q_pop_up;
              step_nxt   = q_pop_up ? '0 : STEP_TOP;
              active_nxt = 1'b1;
              pot_nxt[0] = in_data.pot_a;
              pot_nxt[1] = in_data.pot_b;
              pot_nxt[2] = in_data.pot_c;
              pot_nxt[3] = in_data.pot_d;
              ch_nxt     = '0;
              ph_nxt     = PH_MUL_LO;
              state_nxt  = ST_INIT;
            end
          end
        end
      end

      ST_INIT: begin
        case (ph_r)
          // y = pot * SCALE_LO
          PH_MUL_LO: begin
            alu_a  = ALU_A_W'(pot_r[ch_r]);
            alu_b  = B_LO;
            ph_nxt = PH_FOLD;
          end
          // y + (y >> 12) + 1; its upper part is floor(y / 4095)
          PH_FOLD: begin
            alu_a       = ALU_A_W'(alu_acc[2*POT_W-1:POT_W]);
            alu_b       = B_ONE;
            alu_c       = alu_acc;
            alu_ctl.cin = 1'b1;
            ph_nxt      = PH_MUL_HI;
          end
          // target = pot * SCALE_HI + floor(y / 4095)
          PH_MUL_HI: begin
            alu_a  = ALU_A_W'(pot_r[ch_r]);
            alu_b  = B_HI;
            alu_c  = alu_acc >> POT_W;
            ph_nxt = PH_RECIP;
          end
          // Quotient estimate of target / RAMP_STEPS.
          PH_RECIP: begin
            tgt_nxt = alu_acc[TGT_W-1:0];
            alu_a   = alu_acc[TGT_W-1:0];
            alu_b   = B_RECIP;
            ph_nxt  = PH_REM;
          end
          // Remainder of the estimate.
          PH_REM: begin
            tq_nxt[ch_r] = alu_acc[2*TGT_W-1:TGT_W];
            alu_a        = alu_acc[2*TGT_W-1:TGT_W];
            alu_b        = B_STEPS;
            alu_c        = ALU_W'(tgt_r);
            alu_ctl.sub  = 1'b1;
            alu_ctl.cin  = 1'b1;
            ph_nxt       = PH_CHECK;
          end
          // Remainder minus RAMP_STEPS, to see whether the estimate was one short.
          PH_CHECK: begin
            tr_nxt[ch_r] = alu_acc[SW-1:0];
            alu_a        = A_STEPS;
            alu_b        = B_ONE;
            alu_c        = alu_acc;
            alu_ctl.sub  = 1'b1;
            alu_ctl.cin  = 1'b1;
            ph_nxt       = PH_FIX;
          end
          // Correct the split and set the starting duty.
          PH_FIX: begin
            if (!acc_neg) begin
              tr_nxt[ch_r] = alu_acc[SW-1:0];
              tq_nxt[ch_r] = tq_r[ch_r] + TGT_W'(1);
            end
            q_nxt[ch_r] = dir_r ? '0 : tgt_r;
            r_nxt[ch_r] = '0;
            if (ch_r == CH_LAST) begin
              state_nxt = ST_EMIT;
            end else begin
              ch_nxt = ch_r + CH_W'(1);
              ph_nxt = PH_MUL_LO;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_STEP: begin
        case (ph_r)
          // Remainder plus or minus the per-step remainder.
          PH_ADD: begin
            alu_a       = ALU_A_W'(tr_r[ch_r]);
            alu_b       = B_ONE;
            alu_c       = ALU_W'(r_r[ch_r]);
            alu_ctl.sub = !dir_r;
            alu_ctl.cin = !dir_r;
            ph_nxt      = PH_WRAP;
          end
          // Wrapped remainder: minus RAMP_STEPS going up, plus going down.
          PH_WRAP: begin
            v_nxt       = alu_acc[SW-1:0];
            vneg_nxt    = acc_neg;
            alu_a       = A_STEPS;
            alu_b       = B_ONE;
            alu_c       = alu_acc;
            alu_ctl.sub = dir_r;
            alu_ctl.cin = dir_r;
            ph_nxt      = PH_CARRY;
          end
          // Pick the remainder and move the quotient by the per-step quotient and carry.
          PH_CARRY: begin
            if (dir_r) begin
              carry        = !acc_neg;
              r_nxt[ch_r]  = carry ? alu_acc[SW-1:0] : v_r;
              alu_ctl.cin  = carry;
            end else begin
              carry        = vneg_r;
              r_nxt[ch_r]  = carry ? alu_acc[SW-1:0] : v_r;
              alu_ctl.sub  = 1'b1;
              alu_ctl.cin  = !carry;
            end
            alu_a  = tq_r[ch_r];
            alu_b  = B_ONE;
            alu_c  = ALU_W'(q_r[ch_r]);
            ph_nxt = PH_STORE;
          end
          PH_STORE: begin
            q_nxt[ch_r] = alu_acc[TGT_W-1:0];
            if (ch_r == CH_LAST) begin
              state_nxt = ST_EMIT;
            end else begin
              ch_nxt = ch_r + CH_W'(1);
              ph_nxt = PH_ADD;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      // Hand the step to the output register once it is free.
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.duty_a     = q_r[0][DUTY_W-1:0];
          out_data_nxt.duty_b     = q_r[1][DUTY_W-1:0];
          out_data_nxt.duty_c     = q_r[2][DUTY_W-1:0];
          out_data_nxt.duty_d     = q_r[3][DUTY_W-1:0];
          out_data_nxt.level      = LEVEL_W'(step_r);
          out_data_nxt.fading_up  = dir_r;
          out_data_nxt.final_step = ramp_last;
          state_nxt               = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_MUL_LO;
      ch_r        <= '0;
      present_r   <= 1'b0;
      active_r    <= 1'b0;
      dir_r       <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      ch_r        <= ch_nxt;
      present_r   <= present_nxt;
      active_r    <= active_nxt;
      dir_r       <= dir_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pot_r      <= pot_nxt;
    q_r        <= q_nxt;
    r_r        <= r_nxt;
    tq_r       <= tq_nxt;
    tr_r       <= tr_nxt;
    tgt_r      <= tgt_nxt;
    v_r        <= v_nxt;
    vneg_r     <= vneg_nxt;
    out_data_r <= out_data_nxt;
  end

  // A new result only comes from the emit state.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result appeared outside the emit state");

  // A step update only runs inside an active fade.
  a_step_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> active_r)
    else $error("step update without an active fade");

  // The step counter stays within the ramp while a fade runs.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (step_r <= STEP_TOP))
    else $error("ramp step out of range");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the presence-driven four-channel LED fade sequencer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import plfs_pkg::*;

  localparam int ITEM_TOTAL   = 1400;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  plfs_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  plfs_out_t out_data;

  // Requests waiting to be driven, and fade steps the block owes us.
  plfs_in_t  pending_req_q[$];
  plfs_out_t expected_duty_q[$];

  // Shadow of the sequencer state.
  bit present_seen = 1'b0;
  bit fade_order_q[$];
  bit fade_on = 1'b0;
  bit fade_up = 1'b0;
  int fade_step = 0;
  int chan_target[4];

  int  request_total = 0;
  int  accepted_count = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  req_taken = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  stall_left = 0;

  presence_led_fade_sequencer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Queue the fade step for the current shadow state.
  function automatic void push_fade_duty();
    plfs_out_t s;
    s.duty_a     = DUTY_W'(chan_target[0] * fade_step / DEF_RAMP_STEPS);
    s.duty_b     = DUTY_W'(chan_target[1] * fade_step / DEF_RAMP_STEPS);
    s.duty_c     = DUTY_W'(chan_target[2] * fade_step / DEF_RAMP_STEPS);
    s.duty_d     = DUTY_W'(chan_target[3] * fade_step / DEF_RAMP_STEPS);
    s.level      = LEVEL_W'(fade_step);
    s.fading_up  = fade_up;
    s.final_step = fade_up ? (fade_step >= DEF_RAMP_STEPS) : (fade_step == 0);
    expected_duty_q.push_back(s);
  endfunction

  // Advance the shadow state by one accepted request.
  function automatic void apply_fade_request(plfs_in_t r);
    int pots[4];
    bit at_end;
    pots = '{r.pot_a, r.pot_b, r.pot_c, r.pot_d};
    // A pin change queues a fade order unless the queue is full.
    if (r.command == CMD_SAMPLE) begin
      if (r.pin_level != present_seen) begin
        present_seen = r.pin_level;
        if (fade_order_q.size() < DEF_QUEUE_DEPTH) fade_order_q.push_back(r.pin_level);
      end
      return;
    end
    // A running fade moves one step, or ends after its last step.
    if (fade_on) begin
      at_end = fade_up ? (fade_step >= DEF_RAMP_STEPS) : (fade_step == 0);
      if (!at_end) begin
        fade_step = fade_up ? fade_step + 1 : fade_step - 1;
        push_fade_duty();
        return;
      end
      fade_on = 1'b0;
    end
    // An idle block starts the oldest order and latches the pots.
    if (fade_order_q.size() == 0) return;
    fade_up = fade_order_q.pop_front();
    for (int k = 0; k < NUM_CH; k++) chan_target[k] = pots[k] * DEF_PWM_TOP / POT_FULL;
    fade_on = 1'b1;
    fade_step = fade_up ? 0 : DEF_RAMP_STEPS;
    push_fade_duty();
  endfunction

  // Pot values lean toward the ends of the range.
  function automatic logic [POT_W-1:0] pick_pot();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return POT_W'($urandom_range(POT_FULL));
    endcase
  endfunction

  task automatic queue_request(logic cmd, logic pin, logic [POT_W-1:0] a,
                               logic [POT_W-1:0] b, logic [POT_W-1:0] c,
                               logic [POT_W-1:0] d);
    plfs_in_t r;
    r.command   = cmd;
    r.pin_level = pin;
    r.pot_a     = a;
    r.pot_b     = b;
    r.pot_c     = c;
    r.pot_d     = d;
    pending_req_q.push_back(r);
  endtask

  // Driver: bursts of requests with random gaps, payload held while stalled.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // Stalled: keep the request as it is.
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_req_q.size() == 0) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= 1'b1;
      in_data <= pending_req_q.pop_front();
      if (burst_left > 1) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= ($urandom_range(4) == 0) ? 60 : $urandom_range(12, 1);
        gap_left <= ($urandom_range(3) == 0) ? $urandom_range(35, 1) : $urandom_range(3);
      end
    end
  end

  // Receiver stall pattern: free stretches, stall runs and random chatter.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(5))
        0: begin
          out_stall <= 1'b0;
          stall_left <= $urandom_range(300, 100);
        end
        1: begin
          out_stall <= 1'b1;
          stall_left <= $urandom_range(20, 1);
        end
        default: begin
          out_stall <= ($urandom_range(2) == 0);
          stall_left <= $urandom_range(4, 1);
        end
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Monitor: check each accepted fade step, then predict from the accepted request.
  always @(posedge clk) begin
    plfs_out_t want;
    req_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_duty_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("Unexpected fade step: level %0d up %0b final %0b",
                   out_data.level, out_data.fading_up, out_data.final_step);
      end else begin
        want = expected_duty_q.pop_front();
        if (out_data.duty_a !== want.duty_a || out_data.duty_b !== want.duty_b ||
            out_data.duty_c !== want.duty_c || out_data.duty_d !== want.duty_d ||
            out_data.level !== want.level || out_data.fading_up !== want.fading_up ||
            out_data.final_step !== want.final_step) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("Fade step mismatch at %0t", $realtime);
            $display("  expected duty %0d %0d %0d %0d level %0d up %0b final %0b",
                     want.duty_a, want.duty_b, want.duty_c, want.duty_d,
                     want.level, want.fading_up, want.final_step);
            $display("  actual   duty %0d %0d %0d %0d level %0d up %0b final %0b",
                     out_data.duty_a, out_data.duty_b, out_data.duty_c, out_data.duty_d,
                     out_data.level, out_data.fading_up, out_data.final_step);
          end
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      apply_fade_request(in_data);
      accepted_count++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int       seg_left;
    int       sample_pct;
    bit       gen_pin;
    plfs_in_t item;
    seg_left = 0;
    sample_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;

    // Directed: idle tick, unchanged pin, queue filled to overflow, a fade started at full-scale pots.
    queue_request(CMD_TICK, 1'b0, '1, '1, '1, '1);
    queue_request(CMD_SAMPLE, 1'b0, '1, '0, '1, '0);
    queue_request(CMD_SAMPLE, 1'b1, pick_pot(), pick_pot(), pick_pot(), pick_pot());
    queue_request(CMD_SAMPLE, 1'b1, pick_pot(), pick_pot(), pick_pot(), pick_pot());
    queue_request(CMD_SAMPLE, 1'b0, pick_pot(), pick_pot(), pick_pot(), pick_pot());
    queue_request(CMD_SAMPLE, 1'b1, pick_pot(), pick_pot(), pick_pot(), pick_pot());
    queue_request(CMD_SAMPLE, 1'b0, pick_pot(), pick_pot(), pick_pot(), pick_pot());
    queue_request(CMD_SAMPLE, 1'b1, pick_pot(), pick_pot(), pick_pot(), pick_pot());
    // The queue is full now, so these two orders are dropped.
    queue_request(CMD_SAMPLE, 1'b0, pick_pot(), pick_pot(), pick_pot(), pick_pot());
    queue_request(CMD_SAMPLE, 1'b1, pick_pot(), pick_pot(), pick_pot(), pick_pot());
    queue_request(CMD_TICK, 1'b1, '1, '1, '1, '1);
    queue_request(CMD_TICK, 1'b0, '0, '0, '0, '0);
    queue_request(CMD_SAMPLE, 1'b0, '1, '1, '1, '1);
    gen_pin = 1'b0;

    // Random: mostly ticks to run fades, in segments with varying pin activity.
    while (pending_req_q.size() < ITEM_TOTAL) begin
      if (seg_left == 0) begin
        case ($urandom_range(4))
          0, 1: sample_pct = 0;
          2: sample_pct = 3;
          3: sample_pct = 10;
          default: sample_pct = 40;
        endcase
        seg_left = $urandom_range(300, 20);
      end
      seg_left--;
      item.pot_a = pick_pot();
      item.pot_b = pick_pot();
      item.pot_c = pick_pot();
      item.pot_d = pick_pot();
      if ($urandom_range(99) < sample_pct) begin
        item.command = CMD_SAMPLE;
        if ($urandom_range(3) != 0) gen_pin = ~gen_pin;
        item.pin_level = gen_pin;
      end else begin
        item.command = CMD_TICK;
        item.pin_level = 1'($urandom_range(1));
      end
      pending_req_q.push_back(item);
    end
    request_total = pending_req_q.size();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_count < request_total || expected_duty_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
